@@ rtl/core/tiled_view_address_remap_core_defines.svh @@
// Assertion macros used by the tiled view remap core.
`ifndef TILED_VIEW_ADDRESS_REMAP_CORE_DEFINES_SVH
`define TILED_VIEW_ADDRESS_REMAP_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define TVAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TVAR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/tvar_pkg.sv @@
// Constants and helpers shared by the tiled view remap RTL.
`timescale 1ns / 1ps

package tvar_pkg;

    // Configuration register layout.
    localparam int CFG_W       = 16;
    localparam int REG_AXES    = 4;
    localparam int AX_IDX_W    = $clog2(REG_AXES);
    localparam int CFG_IDX_W   = AX_IDX_W + 1;
    localparam int FIELD_W     = 32;

    // Register indexes: extents first, then repeat counts.
    localparam logic [CFG_IDX_W-1:0] REG_PE_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RP_BASE = CFG_IDX_W'(REG_AXES);

    // A register holding zero acts as one.
    function automatic logic [CFG_W-1:0] nz(input logic [CFG_W-1:0] v);
        nz = (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

@@ rtl/core/tiled_view_address_remap_core.sv @@
// Top level of the tiled view address remap pipeline.
//
// Usage: a view address word is taken at a clock edge where start is high
// and busy is low. busy is high during reset and in the first cycle after
// it, and is low otherwise, so one word can enter on every cycle.
// Each accepted word gives exactly one result word on o_parent_address,
// o_out_of_range and o_list_end_out, shown for one cycle with o_strobe.
// Results leave in the order the words came in.
// Each of the U = min(AXES, 4) axis sections holds two bit-per-stage
// dividers of RW = min(ADDR_WIDTH, 32) bits (by the parent extent,
// then by the repeat count) and, between them, a multiply and an add
// stage that fold the axis index into the parent address; an input
// register comes before the sections and an output register after them.
// Throughput: one word per cycle while busy is low.
// Configuration: eight 16-bit registers (extents 0..3, repeats 0..3),
// written through i_cfg_we / i_cfg_idx / i_cfg_data while no word is in
// flight. Reset sets every register to 1 and empties the pipeline.
// The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
`include "tiled_view_address_remap_core_defines.svh"

module tiled_view_address_remap_core #(
    parameter int AXES       = 4,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tvar_pkg::FIELD_W-1:0]    i_view_address,
    input  logic                            i_list_end,
    input  logic                            i_cfg_we,
    input  logic [tvar_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tvar_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                            o_strobe,
    output logic [tvar_pkg::FIELD_W-1:0]    o_parent_address,
    output logic                            o_out_of_range,
    output logic                            o_list_end_out
);

    localparam int NAX = tvar_pkg::REG_AXES;
    localparam int CW  = tvar_pkg::CFG_W;
    localparam int U   = (AXES < NAX) ? AXES : NAX;
    localparam int RW  = (ADDR_WIDTH < tvar_pkg::FIELD_W) ? ADDR_WIDTH : tvar_pkg::FIELD_W;

    // Configuration registers.
    logic [CW-1:0] r_pe [NAX];
    logic [CW-1:0] r_rp [NAX];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NAX; k++) begin
                r_pe[k] <= CW'(1);
                r_rp[k] <= CW'(1);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx < tvar_pkg::REG_RP_BASE) begin
                r_pe[i_cfg_idx[tvar_pkg::AX_IDX_W-1:0]] <= i_cfg_data;
            end else begin
                r_rp[i_cfg_idx[tvar_pkg::AX_IDX_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // Parent strides, built as a registered product chain from the innermost axis.
    logic [RW-1:0] w_stride [NAX];
    assign w_stride[NAX-1] = RW'(1);

    for (genvar k = 0; k < NAX - 1; k++) begin : g_stride
        logic [RW+CW-1:0] n_prod;
        logic [RW-1:0]    r_stride;
        assign n_prod = w_stride[k+1] * tvar_pkg::nz(r_pe[k+1]);
        always_ff @(posedge i_clk) begin
            r_stride <= n_prod[RW-1:0];
        end
        assign w_stride[k] = r_stride;
    end

    // Busy only while coming out of reset.
    logic r_busy;
    always_ff @(posedge i_clk) begin
        r_busy <= !i_rst_n;
    end
    assign busy = r_busy;

    // Input register.
    logic          r_in_valid;
    logic [RW-1:0] r_in_addr;
    logic          r_in_le;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_addr <= i_view_address[RW-1:0];
        r_in_le   <= i_list_end;
    end

    // Chain between axis sections; section j handles axis NAX-1-j.
    logic          c_v   [U+1];
    logic [RW-1:0] c_rem [U+1];
    logic          c_le  [U+1];
    logic [RW-1:0] c_pa  [U+1];

    assign c_v[0]   = r_in_valid;
    assign c_rem[0] = r_in_addr;
    assign c_le[0]  = r_in_le;
    assign c_pa[0]  = '0;

    for (genvar j = 0; j < U; j++) begin : g_axis
        localparam int K = NAX - 1 - j;

        logic          a_v;
        logic [RW-1:0] a_quo;
        logic [CW-1:0] a_rem;
        logic [RW:0]   a_side;
        logic [RW:0]   b_side;

        // Split off the parent index: rem mod extent, and rem / extent.
        tvar_div #(
            .NW (RW),
            .SW (RW + 1)
        ) u_div_pe (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_v[j]),
            .i_num   (c_rem[j]),
            .i_den   (tvar_pkg::nz(r_pe[K])),
            .i_side  ({c_le[j], c_pa[j]}),
            .o_valid (a_v),
            .o_quo   (a_quo),
            .o_rem   (a_rem),
            .o_side  (a_side)
        );

        // Scale the parent index by the axis stride.
        logic             r_m1_v;
        logic [RW-1:0]    r_m1_q;
        logic [RW-1:0]    r_m1_prod;
        logic             r_m1_le;
        logic [RW-1:0]    r_m1_pa;
        logic [RW+CW-1:0] n_prod;

        assign n_prod = a_rem * w_stride[K];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m1_v <= 1'b0;
            end else begin
                r_m1_v <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_m1_q    <= a_quo;
            r_m1_prod <= n_prod[RW-1:0];
            r_m1_le   <= a_side[RW];
            r_m1_pa   <= a_side[RW-1:0];
        end

        // Accumulate into the parent address.
        logic          r_m2_v;
        logic [RW-1:0] r_m2_q;
        logic          r_m2_le;
        logic [RW-1:0] r_m2_pa;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m2_v <= 1'b0;
            end else begin
                r_m2_v <= r_m1_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_m2_q  <= r_m1_q;
            r_m2_le <= r_m1_le;
            r_m2_pa <= r_m1_pa + r_m1_prod;
        end

        // Drop the tile repeat: quotient / repeat is what the next axis splits.
        tvar_div #(
            .NW (RW),
            .SW (RW + 1)
        ) u_div_rp (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_m2_v),
            .i_num   (r_m2_q),
            .i_den   (tvar_pkg::nz(r_rp[K])),
            .i_side  ({r_m2_le, r_m2_pa}),
            .o_valid (c_v[j+1]),
            .o_quo   (c_rem[j+1]),
            .o_rem   (),
            .o_side  (b_side)
        );

        assign c_le[j+1] = b_side[RW];
        assign c_pa[j+1] = b_side[RW-1:0];
    end

    // Output register; anything left above the outermost axis is past the view.
    logic          r_out_v;
    logic [RW-1:0] r_out_pa;
    logic          r_out_oor;
    logic          r_out_le;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= c_v[U];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pa  <= c_pa[U];
        r_out_oor <= (c_rem[U] != '0);
        r_out_le  <= c_le[U];
    end

    assign o_strobe         = r_out_v;
    assign o_parent_address = tvar_pkg::FIELD_W'(r_out_pa);
    assign o_out_of_range   = r_out_oor;
    assign o_list_end_out   = r_out_le;

    // Checks.
    `TVAR_ASSERT_NEXT(a_accept_enters, start && !busy, r_in_valid, "accepted word did not enter")
    `TVAR_ASSERT_NEXT(a_last_to_out, c_v[U], o_strobe, "finished word did not reach the output")
    `TVAR_ASSERT_SAME(a_strobe_source, o_strobe, $past(c_v[U]), "strobe without a finished word")

endmodule

@@ rtl/core/tvar_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
`timescale 1ns / 1ps

module tvar_div #(
    parameter int NW = 32,
    parameter int SW = 33
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [NW-1:0]               i_num,
    input  logic [tvar_pkg::CFG_W-1:0]  i_den,
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output logic [NW-1:0]               o_quo,
    output logic [tvar_pkg::CFG_W-1:0]  o_rem,
    output logic [SW-1:0]               o_side
);

    localparam int DW = tvar_pkg::CFG_W;

    logic          r_v [NW];
    logic [NW-1:0] r_n [NW];
    logic [DW-1:0] r_r [NW];
    logic [SW-1:0] r_s [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic          sv;
        logic [NW-1:0] sn;
        logic [DW-1:0] sr;
        logic [SW-1:0] ss;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;
        logic [NW-1:0] n_quo;
        logic [DW-1:0] n_rem;

        // Stage input: ports for the first stage, else the previous stage.
        if (s == 0) begin : g_first
            assign sv = i_valid;
            assign sn = i_num;
            assign sr = '0;
            assign ss = i_side;
        end else begin : g_rest
            assign sv = r_v[s-1];
            assign sn = r_n[s-1];
            assign sr = r_r[s-1];
            assign ss = r_s[s-1];
        end

        // Shift in the next dividend bit and try to subtract.
        assign t     = {sr, sn[NW-1]};
        assign diff  = t - {1'b0, i_den};
        assign ge    = (t >= {1'b0, i_den});
        assign n_quo = {sn[NW-2:0], ge};
        assign n_rem = ge ? diff[DW-1:0] : t[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= sv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_n[s] <= n_quo;
            r_r[s] <= n_rem;
            r_s[s] <= ss;
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_n[NW-1];
    assign o_rem   = r_r[NW-1];
    assign o_side  = r_s[NW-1];

endmodule
